[src/rrb_pkg.sv]
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared types, register map and arithmetic helpers for the RGB565 blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rrb_pkg;

	// Fixed field widths
	localparam int PIX_BITS  = 16;
	localparam int OADDR_BITS = 20;
	localparam int GEOM_BITS = 13;
	localparam int WGT_BITS  = 7;

	// Defaults for the top-level parameters
	localparam int DEF_ADDR_BITS = 20;
	localparam int DEF_DIM_BITS  = 12;

	// Decoupling queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = 3;

	// Register reset values
	localparam logic [GEOM_BITS-1:0] STRIDE_RST = 13'd640;
	localparam logic [GEOM_BITS-1:0] LEN_RST    = 13'd1;
	localparam logic [GEOM_BITS-1:0] CNT_RST    = 13'd1;

	// Blend weight saturation and reciprocal of 100 (floor(x*5243 >> 19) == x/100
	// for every x below 25600)
	localparam logic [WGT_BITS-1:0] WGT_FULL   = 7'd100;
	localparam logic [12:0]         DIV100_MUL = 13'd5243;
	localparam int                  DIV100_SHR = 19;

	typedef enum logic [1:0] {
		MODE_COPY  = 2'd0,
		MODE_KEY   = 2'd1,
		MODE_BLEND = 2'd2,
		MODE_XOR   = 2'd3
	} rop_mode_t;

	typedef enum logic [2:0] {
		REG_BLEND_MODE  = 3'd0,
		REG_KEY_COLOR   = 3'd1,
		REG_SEE_THROUGH = 3'd2,
		REG_DST_START   = 3'd3,
		REG_DST_STRIDE  = 3'd4,
		REG_ROW_LENGTH  = 3'd5,
		REG_ROW_COUNT   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] src_pixel;
		logic [PIX_BITS-1:0] dst_pixel;
	} req_item_t;

	typedef struct packed {
		logic [PIX_BITS-1:0]   out_pixel;
		logic                  write_enable;
		logic [OADDR_BITS-1:0] dst_addr;
		logic                  last;
	} res_item_t;

	// Front-end view of the configuration
	typedef struct packed {
		logic [OADDR_BITS-1:0] dst_start;
		logic [GEOM_BITS-1:0]  dst_stride;
		logic [GEOM_BITS-1:0]  row_length;
		logic [GEOM_BITS-1:0]  row_count;
		logic [PIX_BITS-1:0]   key_color;
	} walk_cfg_t;

	// Back-end view of the configuration
	typedef struct packed {
		rop_mode_t           mode;
		logic [WGT_BITS-1:0] weight;   // saturated to 100
	} rop_cfg_t;

	// Classified request as queued between front and back
	typedef struct packed {
		logic [PIX_BITS-1:0]   src_pixel;
		logic [PIX_BITS-1:0]   dst_pixel;
		logic                  key_hit;
		logic [OADDR_BITS-1:0] dst_addr;
		logic                  last;
	} entry_t;

	typedef struct packed {
		logic                 full;
		logic                 empty;
		logic [QCNT_BITS-1:0] count;
	} q_status_t;

	// floor(x / 100) for x < 25600
	function automatic logic [7:0] div100(input logic [14:0] x);
		logic [27:0] p;
		p = 28'(x) * 28'(DIV100_MUL);
		return p[DIV100_SHR+7:DIV100_SHR];
	endfunction

endpackage

`default_nettype wire

[src/rgb565_raster_blit_core.sv]
// ----------------------------------------------------------------------------
// rgb565_raster_blit_core
// RGB565 raster-op blitter: walks a destination rectangle and produces one
// write request per source/destination pixel pair.
// ----------------------------------------------------------------------------
// Each request carries a source pixel and the destination pixel currently at
// the walked position; each result gives the pixel to write, a write enable,
// the destination address and a last-of-rectangle mark. The block sustains
// one request per clock while results are taken: the front end tags a
// request in the cycle it is accepted, a four-entry queue buffers it, and
// the back end's two register stages (channel products/sums, then
// divide-by-100, mode select and output register) each advance one request
// per clock unless the output holds a stalled result. Requests keep flowing
// while a result is stalled until the queue fills, so the input only stalls
// once four requests wait in the queue behind a held output (plus any
// request already in stage one). Modes: 0 copy, 1 color-keyed copy
// (write_enable low and destination pixel passed through on a key match),
// 2 percent blend with see_through (saturated at 100) as the weight of the
// old destination pixel, 3 XOR. Writing dst_start, dst_stride, row_length or
// row_count restarts the walk at the top-left corner; the other registers
// take effect on the next request. Program registers only while no request
// is in flight. Registers sit at byte address 4*index on the APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_raster_blit_core
	import rrb_pkg::*;
#(
	parameter int ADDR_BITS = DEF_ADDR_BITS,
	parameter int DIM_BITS  = DEF_DIM_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_item_t   req_data,
	// result channel
	output logic             res_valid,
	input  wire logic        res_stall,
	output res_item_t        res_data,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// Configuration registers
	rop_mode_t             blend_mode_q;
	logic [PIX_BITS-1:0]   key_color_q;
	logic [WGT_BITS-1:0]   see_through_q;
	logic [OADDR_BITS-1:0] dst_start_q;
	logic [GEOM_BITS-1:0]  dst_stride_q;
	logic [GEOM_BITS-1:0]  row_length_q;
	logic [GEOM_BITS-1:0]  row_count_q;

	logic      reg_wr;
	reg_idx_t  reg_idx;
	logic      restart;

	walk_cfg_t walk_cfg;
	rop_cfg_t  rop_cfg;

	logic      push, pop;
	entry_t    wr_entry, rd_entry;
	q_status_t q_status;

	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	// Geometry writes restart the walk
	always_comb begin
		case (reg_idx)
			REG_DST_START, REG_DST_STRIDE, REG_ROW_LENGTH, REG_ROW_COUNT: begin
				restart = reg_wr;
			end
			default: begin
				restart = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q  <= MODE_COPY;
			key_color_q   <= '0;
			see_through_q <= '0;
			dst_start_q   <= '0;
			dst_stride_q  <= STRIDE_RST;
			row_length_q  <= LEN_RST;
			row_count_q   <= CNT_RST;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_BLEND_MODE:  blend_mode_q  <= rop_mode_t'(pwdata[1:0]);
				REG_KEY_COLOR:   key_color_q   <= pwdata[PIX_BITS-1:0];
				REG_SEE_THROUGH: see_through_q <= pwdata[WGT_BITS-1:0];
				REG_DST_START:   dst_start_q   <= pwdata[OADDR_BITS-1:0];
				REG_DST_STRIDE:  dst_stride_q  <= pwdata[GEOM_BITS-1:0];
				REG_ROW_LENGTH:  row_length_q  <= pwdata[GEOM_BITS-1:0];
				REG_ROW_COUNT:   row_count_q   <= pwdata[GEOM_BITS-1:0];
				default:         ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx)
			REG_BLEND_MODE:  prdata = 32'(blend_mode_q);
			REG_KEY_COLOR:   prdata = 32'(key_color_q);
			REG_SEE_THROUGH: prdata = 32'(see_through_q);
			REG_DST_START:   prdata = 32'(dst_start_q);
			REG_DST_STRIDE:  prdata = 32'(dst_stride_q);
			REG_ROW_LENGTH:  prdata = 32'(row_length_q);
			REG_ROW_COUNT:   prdata = 32'(row_count_q);
			default:         prdata = '0;
		endcase
	end

	// A dst_start write restarts the walk from the new corner at the same edge
	assign walk_cfg.dst_start  = (reg_wr && reg_idx == REG_DST_START) ?
	                             pwdata[OADDR_BITS-1:0] : dst_start_q;
	assign walk_cfg.dst_stride = dst_stride_q;
	assign walk_cfg.row_length = row_length_q;
	assign walk_cfg.row_count  = row_count_q;
	assign walk_cfg.key_color  = key_color_q;

	// Blend weight saturates at 100 percent
	assign rop_cfg.mode   = blend_mode_q;
	assign rop_cfg.weight = (see_through_q > WGT_FULL) ? WGT_FULL : see_through_q;

	rrb_front #(
		.ADDR_BITS (ADDR_BITS),
		.DIM_BITS  (DIM_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.cfg       (walk_cfg),
		.req_valid (req_valid),
		.req_data  (req_data),
		.req_stall (req_stall),
		.q_status  (q_status),
		.push      (push),
		.entry     (wr_entry)
	);

	rrb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.status   (q_status)
	);

	rrb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (rop_cfg),
		.q_status  (q_status),
		.rd_entry  (rd_entry),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

`ifndef SYNTHESIS
	// Only keyed copy may suppress a write
	a_we_only_keyed: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.write_enable) |-> (blend_mode_q == MODE_KEY))
		else $error("write suppressed outside keyed mode");

	// Queue never overflows or underflows
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (q_status.count != '0))
		else $error("pop from empty queue");

	// A stalled result and a full queue stop the input on the next cycle
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(q_status.full && res_valid && res_stall) |=> req_stall)
		else $error("queue full but input not stalled");
`endif

endmodule

`default_nettype wire

[src/rrb_queue.sv]
// ----------------------------------------------------------------------------
// rrb_queue
// Small FIFO that decouples the address walker from the raster-op pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rrb_queue
	import rrb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire entry_t    wr_entry,
	input  wire logic      pop,
	output entry_t         rd_entry,
	output q_status_t      status
);

	entry_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_BITS'(1);
				2'b01:   count_q <= count_q - QCNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_entry     = slot_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign status.count = count_q;

endmodule

`default_nettype wire

[src/rrb_front.sv]
// ----------------------------------------------------------------------------
// rrb_front
// Accepts pixel requests, walks the destination rectangle and tags each
// request with its address, last mark and color-key match.
// ----------------------------------------------------------------------------
`default_nettype none

module rrb_front
	import rrb_pkg::*;
#(
	parameter int ADDR_BITS = DEF_ADDR_BITS,
	parameter int DIM_BITS  = DEF_DIM_BITS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      restart,
	input  wire walk_cfg_t cfg,
	input  wire logic      req_valid,
	input  wire req_item_t req_data,
	output logic           req_stall,
	input  wire q_status_t q_status,
	output logic           push,
	output entry_t         entry
);

	localparam int CmpBits  = (DIM_BITS + 1 > GEOM_BITS) ? DIM_BITS + 1 : GEOM_BITS;
	localparam int AExtBits = (ADDR_BITS > OADDR_BITS) ? ADDR_BITS : OADDR_BITS;
	localparam logic [CmpBits-1:0] DimMax = CmpBits'(1) << DIM_BITS;

	logic [DIM_BITS-1:0]  col_q;
	logic [DIM_BITS-1:0]  row_q;
	logic [ADDR_BITS-1:0] base_q;

	logic [CmpBits-1:0]   len_raw, cnt_raw, len_c, cnt_c;
	logic [CmpBits-1:0]   col_nxt, row_nxt;
	logic                 end_row, end_rect;
	logic [ADDR_BITS-1:0] addr;
	logic [AExtBits-1:0]  addr_ext;

	// Clamp dimensions to 1 .. 2^DIM_BITS
	always_comb begin
		len_raw = CmpBits'(cfg.row_length);
		cnt_raw = CmpBits'(cfg.row_count);
		if (len_raw == '0) begin
			len_c = CmpBits'(1);
		end else if (len_raw > DimMax) begin
			len_c = DimMax;
		end else begin
			len_c = len_raw;
		end
		if (cnt_raw == '0) begin
			cnt_c = CmpBits'(1);
		end else if (cnt_raw > DimMax) begin
			cnt_c = DimMax;
		end else begin
			cnt_c = cnt_raw;
		end
	end

	assign col_nxt  = CmpBits'(col_q) + CmpBits'(1);
	assign row_nxt  = CmpBits'(row_q) + CmpBits'(1);
	assign end_row  = (col_nxt >= len_c);
	assign end_rect = end_row && (row_nxt >= cnt_c);

	assign addr     = base_q + ADDR_BITS'(col_q);
	assign addr_ext = AExtBits'(addr);

	assign req_stall = q_status.full;
	assign push      = req_valid && !q_status.full;

	assign entry.src_pixel = req_data.src_pixel;
	assign entry.dst_pixel = req_data.dst_pixel;
	assign entry.key_hit   = (req_data.src_pixel == cfg.key_color);
	assign entry.dst_addr  = addr_ext[OADDR_BITS-1:0];
	assign entry.last      = end_rect;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			base_q <= '0;
		end else if (restart || (push && end_rect)) begin
			col_q  <= '0;
			row_q  <= '0;
			base_q <= ADDR_BITS'(cfg.dst_start);
		end else if (push && end_row) begin
			col_q  <= '0;
			row_q  <= row_q + DIM_BITS'(1);
			base_q <= base_q + ADDR_BITS'(cfg.dst_stride);
		end else if (push) begin
			col_q  <= col_q + DIM_BITS'(1);
		end
	end

endmodule

`default_nettype wire

[src/rrb_back.sv]
// ----------------------------------------------------------------------------
// rrb_back
// Raster-op pipeline: weighted channel sums, divide by 100, mode select and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrb_back
	import rrb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire rop_cfg_t  cfg,
	input  wire q_status_t q_status,
	input  wire entry_t    rd_entry,
	output logic           pop,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_item_t      res_data
);

	logic        adv;
	logic [6:0]  inv_w;
	logic [7:0]  sr, sg, sb, dr, dg, db;

	logic        valid_s1;
	entry_t      ent_s1;
	logic [14:0] sum_r_s1, sum_g_s1, sum_b_s1;

	logic [7:0]  qr, qg, qb;
	logic [PIX_BITS-1:0] blend_pix;
	res_item_t   res_nxt;
	logic        res_valid_q;
	res_item_t   res_q;

	// Whole pipeline moves unless the output holds a stalled result
	assign adv = !res_valid_q || !res_stall;
	assign pop = !q_status.empty && adv;

	// Channels widened to 8 bits with zero low bits
	assign sr = {rd_entry.src_pixel[15:11], 3'b000};
	assign sg = {rd_entry.src_pixel[10:5],  2'b00};
	assign sb = {rd_entry.src_pixel[4:0],   3'b000};
	assign dr = {rd_entry.dst_pixel[15:11], 3'b000};
	assign dg = {rd_entry.dst_pixel[10:5],  2'b00};
	assign db = {rd_entry.dst_pixel[4:0],   3'b000};
	assign inv_w = WGT_FULL - cfg.weight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1   <= rd_entry;
			sum_r_s1 <= 15'(sr) * 15'(inv_w) + 15'(dr) * 15'(cfg.weight);
			sum_g_s1 <= 15'(sg) * 15'(inv_w) + 15'(dg) * 15'(cfg.weight);
			sum_b_s1 <= 15'(sb) * 15'(inv_w) + 15'(db) * 15'(cfg.weight);
		end
	end

	assign qr = div100(sum_r_s1);
	assign qg = div100(sum_g_s1);
	assign qb = div100(sum_b_s1);
	assign blend_pix = {qr[7:3], qg[7:2], qb[7:3]};

	always_comb begin
		res_nxt.write_enable = 1'b1;
		res_nxt.dst_addr     = ent_s1.dst_addr;
		res_nxt.last         = ent_s1.last;
		case (cfg.mode)
			MODE_COPY: begin
				res_nxt.out_pixel = ent_s1.src_pixel;
			end
			MODE_KEY: begin
				if (ent_s1.key_hit) begin
					res_nxt.out_pixel    = ent_s1.dst_pixel;
					res_nxt.write_enable = 1'b0;
				end else begin
					res_nxt.out_pixel = ent_s1.src_pixel;
				end
			end
			MODE_BLEND: begin
				res_nxt.out_pixel = blend_pix;
			end
			MODE_XOR: begin
				res_nxt.out_pixel = ent_s1.src_pixel ^ ent_s1.dst_pixel;
			end
			default: begin
				res_nxt.out_pixel = ent_s1.src_pixel;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

`default_nettype wire

[sim/tb_rgb565_raster_blit_core.sv]
// ----------------------------------------------------------------------------
// tb_rgb565_raster_blit_core
// Self-checking testbench for the RGB565 raster-op blitter.
// ----------------------------------------------------------------------------
// A built-in model of the blitter (rectangle walk, address wrap, dimension
// clamping and the four raster ops) predicts every result. Each accepted
// result is compared field by field against the oldest prediction. The
// stimulus starts with a short directed table that covers the extreme pixel
// values, every mode, the key match, blend weight saturation, an unmapped
// register write, address wrap, zero stride and a restart in the middle of a
// walk. It then runs random register settings with random pixel traffic
// and one long hold on the output. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rgb565_raster_blit_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rrb_pkg::*;

	localparam int          ADDR_W       = DEF_ADDR_BITS;
	localparam int          DIM_W        = DEF_DIM_BITS;
	localparam int unsigned DIM_LIMIT    = 1 << DIM_W;
	localparam int          NUM_REGS     = 7;
	localparam logic [2:0]  REG_SPARE    = 3'd7;  // unmapped, writes are dropped
	localparam int          RANDOM_ITEMS = 2000;
	localparam int          HOLD_CYCLES  = 48;    // long output hold, fills the queue
	localparam int          QUIET_LIMIT  = 2000;  // cycles without any handshake

	// ------------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_item_t   req_data;
	logic        res_valid;
	logic        res_stall;
	res_item_t   res_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rgb565_raster_blit_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Blitter model: register shadow plus the walk position
	// ------------------------------------------------------------------------
	logic [31:0]       reg_shadow [0:NUM_REGS-1];
	logic [DIM_W-1:0]  walk_col;
	logic [DIM_W-1:0]  walk_row;
	logic [ADDR_W-1:0] walk_base;

	// Predicted blit writes, oldest first
	res_item_t expected_writes [$];

	// Run bookkeeping
	int unsigned mismatches;
	int unsigned n_requests;
	int unsigned n_results;
	int unsigned n_keyed_out;
	int unsigned n_rect_ends;
	int unsigned n_settings;
	int unsigned n_reg_writes;

	// Per-phase traffic shape, read by the sender and the drain process
	bit fast_send;
	bit fast_drain;
	bit hold_output;

	function automatic logic [31:0] reg_mask(input logic [2:0] idx);
		case (idx)
			REG_BLEND_MODE:  return 32'h0000_0003;
			REG_KEY_COLOR:   return 32'h0000_FFFF;
			REG_SEE_THROUGH: return 32'h0000_007F;
			REG_DST_START:   return 32'h000F_FFFF;
			REG_DST_STRIDE,
			REG_ROW_LENGTH,
			REG_ROW_COUNT:   return 32'h0000_1FFF;
			default:         return 32'h0;
		endcase
	endfunction

	function automatic void restart_walk();
		walk_col  = '0;
		walk_row  = '0;
		walk_base = reg_shadow[REG_DST_START][ADDR_W-1:0];
	endfunction

	function automatic void cfg_apply(input logic [2:0] idx, input logic [31:0] value);
		if (idx <= REG_ROW_COUNT) begin
			reg_shadow[idx] = value & reg_mask(idx);
			// geometry registers restart the walk, op registers do not
			if (idx >= REG_DST_START)
				restart_walk();
		end
	endfunction

	function automatic int unsigned clamp_dim(input logic [31:0] v);
		if (v == 0)
			return 1;
		if (v > DIM_LIMIT)
			return DIM_LIMIT;
		return v;
	endfunction

	function automatic int unsigned mix8(input int unsigned s, input int unsigned d,
			input int unsigned a);
		return (s * (100 - a) + d * a) / 100;
	endfunction

	// Channels widened to 8 bits with zero fill, mixed, then top 5/6/5 kept
	function automatic logic [15:0] blend_rgb565(input logic [15:0] s, input logic [15:0] d,
			input int unsigned a);
		int unsigned r, g, b;
		r = mix8({s[15:11], 3'b0}, {d[15:11], 3'b0}, a);
		g = mix8({s[10:5], 2'b0}, {d[10:5], 2'b0}, a);
		b = mix8({s[4:0], 3'b0}, {d[4:0], 3'b0}, a);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// Works out one blit write and advances the walk
	function automatic res_item_t predict_blit(input req_item_t rq);
		res_item_t   r;
		int unsigned len, cnt, wgt;
		bit          end_row, end_rect;
		len      = clamp_dim(reg_shadow[REG_ROW_LENGTH]);
		cnt      = clamp_dim(reg_shadow[REG_ROW_COUNT]);
		wgt      = (reg_shadow[REG_SEE_THROUGH] > 100) ? 100 : reg_shadow[REG_SEE_THROUGH];
		end_row  = (int'(walk_col) + 1) >= len;
		end_rect = end_row && ((int'(walk_row) + 1) >= cnt);

		r.dst_addr     = walk_base + walk_col;
		r.write_enable = 1'b1;
		r.last         = end_rect;
		case (rop_mode_t'(reg_shadow[REG_BLEND_MODE][1:0]))
			MODE_COPY:  r.out_pixel = rq.src_pixel;
			MODE_KEY: begin
				if (rq.src_pixel == reg_shadow[REG_KEY_COLOR][15:0]) begin
					r.out_pixel    = rq.dst_pixel;
					r.write_enable = 1'b0;
				end else
					r.out_pixel = rq.src_pixel;
			end
			MODE_BLEND: r.out_pixel = blend_rgb565(rq.src_pixel, rq.dst_pixel, wgt);
			default:    r.out_pixel = rq.src_pixel ^ rq.dst_pixel;
		endcase

		if (end_rect)
			restart_walk();
		else if (end_row) begin
			walk_col  = '0;
			walk_row  = walk_row + 1'b1;
			walk_base = walk_base + reg_shadow[REG_DST_STRIDE][12:0];
		end else
			walk_col = walk_col + 1'b1;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic check_write(input res_item_t got);
		res_item_t want;
		n_results++;
		if (expected_writes.size() == 0) begin
			report_mismatch("result with nothing pending", got.dst_addr, 0);
		end else begin
			want = expected_writes.pop_front();
			if (got.out_pixel !== want.out_pixel)
				report_mismatch("out_pixel", got.out_pixel, want.out_pixel);
			if (got.write_enable !== want.write_enable)
				report_mismatch("write_enable", got.write_enable, want.write_enable);
			if (got.dst_addr !== want.dst_addr)
				report_mismatch("dst_addr", got.dst_addr, want.dst_addr);
			if (got.last !== want.last)
				report_mismatch("last", got.last, want.last);
			if (!want.write_enable)
				n_keyed_out++;
			if (want.last)
				n_rect_ends++;
		end
	endtask

	// ------------------------------------------------------------------------
	// APB access: setup cycle, access cycle, idle cycle
	// ------------------------------------------------------------------------
	task automatic apb_read(input logic [2:0] idx, output logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write, update the model at the write edge, then read back mapped registers
	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] readback;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		cfg_apply(idx, value);
		n_reg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx <= REG_ROW_COUNT) begin
			apb_read(idx, readback);
			if (readback !== reg_shadow[idx])
				report_mismatch("register readback", readback, reg_shadow[idx]);
		end
	endtask

	// Random junk above the field width checks that unused bits are dropped
	task automatic write_field(input logic [2:0] idx, input logic [31:0] field);
		apb_write(idx, ($urandom & ~reg_mask(idx)) | (field & reg_mask(idx)));
	endtask

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------
	// Returns at the edge that accepts the request; valid stays up so a
	// back-to-back request only changes the payload at the next falling edge.
	task automatic send_pixel(input req_item_t rq, input bit known, input res_item_t want);
		int unsigned gap;
		res_item_t   pred;
		gap = fast_send ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= rq;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		// the walk advances on every request, typed-in rows included
		pred = predict_blit(rq);
		expected_writes.push_back(known ? want : pred);
		n_requests++;
	endtask

	function automatic req_item_t random_pixel();
		req_item_t rq;
		// a quarter of the sources hit the key so keyed mode drops some writes
		rq.src_pixel = ($urandom_range(0, 3) == 0) ? reg_shadow[REG_KEY_COLOR][15:0]
		                                           : 16'($urandom);
		rq.dst_pixel = 16'($urandom);
		return rq;
	endfunction

	// Drop valid and let every pending result drain before touching registers
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);  // two-stage back end, plus margin
	endtask

	// ------------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------------
	typedef enum bit {ROW_WRITE, ROW_PIXEL} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [31:0] value;
		req_item_t   pix;
		bit          known;
		res_item_t   want;
	} stim_row_t;

	stim_row_t directed_rows [$];

	function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] value);
		stim_row_t row;
		row.kind  = ROW_WRITE;
		row.idx   = idx;
		row.value = value;
		row.pix   = '0;
		row.known = 1'b0;
		row.want  = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_pix(input logic [15:0] src, input logic [15:0] dst);
		stim_row_t row;
		row.kind  = ROW_PIXEL;
		row.idx   = '0;
		row.value = '0;
		row.pix   = {src, dst};
		row.known = 1'b0;
		row.want  = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_pix_exp(input logic [15:0] src, input logic [15:0] dst,
			input logic [15:0] out, input bit we, input logic [19:0] addr, input bit last);
		stim_row_t row;
		row.kind  = ROW_PIXEL;
		row.idx   = '0;
		row.value = '0;
		row.pix   = {src, dst};
		row.known = 1'b1;
		row.want  = {out, we, addr, last};
		directed_rows.push_back(row);
	endfunction

	function automatic void build_directed();
		// Reset state: copy into a 1x1 rectangle at address 0, every pixel is last
		add_pix_exp(16'h0000, 16'hFFFF, 16'h0000, 1'b1, 20'h0, 1'b1);
		add_pix_exp(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 20'h0, 1'b1);
		// XOR invert
		add_cfg(REG_BLEND_MODE, MODE_XOR);
		add_pix_exp(16'hA5A5, 16'hFFFF, 16'h5A5A, 1'b1, 20'h0, 1'b1);
		// Keyed copy: match passes the destination through with no write
		add_cfg(REG_KEY_COLOR, 32'h1234);
		add_cfg(REG_BLEND_MODE, MODE_KEY);
		add_pix_exp(16'h1234, 16'hBEEF, 16'hBEEF, 1'b0, 20'h0, 1'b1);
		add_pix_exp(16'h1235, 16'hBEEF, 16'h1235, 1'b1, 20'h0, 1'b1);
		add_cfg(REG_KEY_COLOR, 32'hFFFF);
		add_pix_exp(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 20'h0, 1'b1);
		// Blend: weight 0 keeps the source, 100 and above keep the destination
		add_cfg(REG_BLEND_MODE, MODE_BLEND);
		add_pix_exp(16'hF81F, 16'h07E0, 16'hF81F, 1'b1, 20'h0, 1'b1);
		add_cfg(REG_SEE_THROUGH, 32'd100);
		add_pix_exp(16'hF81F, 16'h07E0, 16'h07E0, 1'b1, 20'h0, 1'b1);
		add_cfg(REG_SEE_THROUGH, 32'd127);
		add_pix_exp(16'h001F, 16'hFFE0, 16'hFFE0, 1'b1, 20'h0, 1'b1);
		add_cfg(REG_SEE_THROUGH, 32'd50);
		add_pix(16'hFFFF, 16'h0000);
		add_pix(16'h8410, 16'h7BEF);
		// Unmapped register: nothing changes
		add_cfg(REG_SPARE, 32'hFFFF_FFFF);
		add_pix(16'h1357, 16'h2468);
		// 3x2 rectangle straddling the top of the address space
		add_cfg(REG_BLEND_MODE, MODE_COPY);
		add_cfg(REG_DST_START, 32'hF_FFFE);
		add_cfg(REG_DST_STRIDE, 32'd4096);
		add_cfg(REG_ROW_LENGTH, 32'd3);
		add_cfg(REG_ROW_COUNT, 32'd2);
		repeat (6) add_pix(16'($urandom), 16'($urandom));
		// Zero stride and zero length (clamped to one)
		add_cfg(REG_DST_STRIDE, 32'd0);
		add_cfg(REG_ROW_LENGTH, 32'd0);
		add_cfg(REG_ROW_COUNT, 32'd2);
		repeat (2) add_pix(16'($urandom), 16'($urandom));
		// Geometry write in the middle of a walk restarts it
		add_cfg(REG_DST_STRIDE, 32'd7);
		add_cfg(REG_ROW_LENGTH, 32'd4);
		add_cfg(REG_ROW_COUNT, 32'd4);
		repeat (2) add_pix(16'($urandom), 16'($urandom));
		add_cfg(REG_DST_START, 32'd100);
		add_pix(16'($urandom), 16'($urandom));
	endfunction

	// ------------------------------------------------------------------------
	// Random register settings
	// ------------------------------------------------------------------------
	function automatic logic [31:0] pick_dim();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return $urandom_range(4096, 8191);
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	task automatic random_setting();
		logic [31:0] v;
		n_settings++;
		if ($urandom_range(0, 2) != 0)
			write_field(REG_BLEND_MODE, $urandom);
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 3))
				0:       v = 32'h0;
				1:       v = 32'hFFFF;
				default: v = $urandom;
			endcase
			write_field(REG_KEY_COLOR, v);
		end
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 4))
				0:       v = 0;
				1:       v = 100;
				2:       v = 127;
				default: v = $urandom_range(0, 127);
			endcase
			write_field(REG_SEE_THROUGH, v);
		end
		// geometry changes are less frequent so walks run across phases
		if ($urandom_range(0, 1) == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 3))
					0:       v = 0;
					1:       v = 32'hF_FFFF;
					default: v = $urandom;
				endcase
				write_field(REG_DST_START, v);
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 4))
					0:       v = 0;
					1:       v = 8191;
					2:       v = 4096;
					default: v = $urandom_range(1, 8191);
				endcase
				write_field(REG_DST_STRIDE, v);
			end
			if ($urandom_range(0, 3) != 0)
				write_field(REG_ROW_LENGTH, pick_dim());
			if ($urandom_range(0, 3) != 0)
				write_field(REG_ROW_COUNT, pick_dim());
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stall ahead of every result, one long hold on demand
	// ------------------------------------------------------------------------
	initial begin : drain_results
		int unsigned hold;
		bit          hold_done;
		res_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = fast_drain ? 0 : $urandom_range(0, 5);
			if (hold_output && !hold_done) begin
				hold      = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			@(negedge clk);
			if (hold != 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid)
				@(posedge clk);
			check_write(res_data);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: any request, result or register transfer counts as progress
	// ------------------------------------------------------------------------
	int unsigned quiet_cycles;

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall)
				|| (psel && penable && pready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] watchdog: no handshake for %0d cycles, %0d results pending",
				$time, quiet_cycles, expected_writes.size());
			$display("end of test: mismatches");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [31:0] readback;
		int unsigned n_random, phase_items, phase;
		res_item_t   no_want;

		req_valid    = 1'b0;
		req_data     = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		arst_n       = 1'b0;
		fast_send    = 1'b0;
		fast_drain   = 1'b0;
		hold_output  = 1'b0;
		no_want      = '0;

		// model reset state
		reg_shadow[REG_BLEND_MODE]  = MODE_COPY;
		reg_shadow[REG_KEY_COLOR]   = 0;
		reg_shadow[REG_SEE_THROUGH] = 0;
		reg_shadow[REG_DST_START]   = 0;
		reg_shadow[REG_DST_STRIDE]  = STRIDE_RST;
		reg_shadow[REG_ROW_LENGTH]  = LEN_RST;
		reg_shadow[REG_ROW_COUNT]   = CNT_RST;
		restart_walk();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every register must read its reset value
		for (int i = 0; i < NUM_REGS; i++) begin
			apb_read(3'(i), readback);
			if (readback !== reg_shadow[i])
				report_mismatch("reset value", readback, reg_shadow[i]);
		end

		// Directed table
		build_directed();
		n_settings = 1;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_drained();
				apb_write(directed_rows[i].idx, directed_rows[i].value);
			end else
				send_pixel(directed_rows[i].pix, directed_rows[i].known,
					directed_rows[i].want);
		end

		// Random phases. Phase 2 runs the sender flat out against a long
		// output hold so the queue fills and the input stalls.
		n_random = 0;
		phase    = 0;
		while (n_random < RANDOM_ITEMS) begin
			wait_drained();
			random_setting();
			fast_send  = ($urandom_range(0, 3) == 0);
			fast_drain = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				fast_send   = 1'b1;
				fast_drain  = 1'b0;
				hold_output = 1'b1;
			end
			phase_items = $urandom_range(20, 120);
			repeat (phase_items)
				send_pixel(random_pixel(), 1'b0, no_want);
			n_random += phase_items;
			phase++;
		end

		wait_drained();
		repeat (8) @(posedge clk);

		$display("Covered %0d pixel requests over %0d register settings (%0d writes).",
			n_requests, n_settings, n_reg_writes);
		$display("%0d results checked, %0d keyed-out pixels, %0d rectangle ends, %0d mismatches.",
			n_results, n_keyed_out, n_rect_ends, mismatches);
		if (mismatches == 0 && expected_writes.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

[rgb565_raster_blit_core.f]
src/rrb_pkg.sv
src/rrb_queue.sv
src/rrb_front.sv
src/rrb_back.sv
src/rgb565_raster_blit_core.sv
sim/tb_rgb565_raster_blit_core.sv
